### design/msk_pkg.sv
// Shared types, codes and widths for the minimum-tracking stack.
package msk_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W = 5;
	localparam int CAP_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int DEFAULT_STACK_DEPTH = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

### design/msk_cfg.sv
// Configuration register bank with the capacity clamp.
module msk_cfg #(
	parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [msk_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [msk_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [msk_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [msk_pkg::CNT_W-1:0]        cap_eff
);

	localparam int DEPTH_LIM = (STACK_DEPTH > 31) ? 31 : STACK_DEPTH;

	logic [msk_pkg::CAP_W-1:0] cap_q;
	logic                      sel_cap;

	assign sel_cap = (paddr[2] == msk_pkg::REG_CAPACITY);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= msk_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && sel_cap) begin
			cap_q <= pwdata[msk_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = msk_pkg::APB_DATA_W'(cap_q);
		end
	end

	// zero acts as one, anything past the storage acts as the storage depth
	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = msk_pkg::CNT_W'(1);
		end else if (cap_q > msk_pkg::CAP_W'(DEPTH_LIM)) begin
			cap_eff = msk_pkg::CNT_W'(DEPTH_LIM);
		end else begin
			cap_eff = msk_pkg::CNT_W'(cap_q);
		end
	end

endmodule

### design/msk_ctrl.sv
// Controller state machine: capture an item, then commit it to the datapath.
module msk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  msk_pkg::dp_stat_t   stat,
	output msk_pkg::ctrl_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_EXEC) && !stat.out_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/msk_dpath.sv
// Datapath: value and prefix-minimum memories, count, minimum and result register.
module msk_dpath #(
	parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msk_pkg::ctrl_cmd_t                 cmd,
	output msk_pkg::dp_stat_t                  stat,
	input  logic [msk_pkg::CNT_W-1:0]          cap_eff,
	input  logic                               mode,
	input  logic signed [msk_pkg::DATA_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [msk_pkg::DATA_W-1:0]  popped_value,
	output logic signed [msk_pkg::DATA_W-1:0]  current_min,
	output logic [msk_pkg::CNT_W-1:0]          entry_count,
	output logic [1:0]                         status
);

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int EXT_W = (IDX_W > msk_pkg::CNT_W) ? IDX_W : msk_pkg::CNT_W;
	localparam int DEPTH_LIM = (STACK_DEPTH > 31) ? 31 : STACK_DEPTH;

	logic [msk_pkg::DATA_W-1:0] value_mem [STACK_DEPTH];
	logic [msk_pkg::DATA_W-1:0] pmin_mem  [STACK_DEPTH];

	logic [msk_pkg::CNT_W-1:0]  count_q;
	logic [msk_pkg::DATA_W-1:0] cur_min_q;
	logic                       op_q;
	logic [msk_pkg::DATA_W-1:0] val_q;
	logic [msk_pkg::DATA_W-1:0] rd_value_q;
	logic [msk_pkg::DATA_W-1:0] rd_pmin_q;

	logic                       out_valid_q;
	logic [msk_pkg::DATA_W-1:0] out_popped_q;
	logic [msk_pkg::DATA_W-1:0] out_min_q;
	logic [msk_pkg::CNT_W-1:0]  out_count_q;
	logic [1:0]                 out_status_q;

	logic [EXT_W-1:0]           count_ext;
	logic [IDX_W-1:0]           top_idx;
	logic [IDX_W-1:0]           below_idx;
	logic [IDX_W-1:0]           wr_idx;

	logic                       push_ok;
	logic                       pop_ok;
	logic [msk_pkg::DATA_W-1:0] push_min;
	logic [msk_pkg::CNT_W-1:0]  count_d;
	logic [msk_pkg::DATA_W-1:0] min_d;
	logic [msk_pkg::DATA_W-1:0] popped_d;
	logic [1:0]                 status_d;

	assign count_ext = EXT_W'(count_q);
	assign top_idx   = IDX_W'(count_ext - EXT_W'(1));
	assign below_idx = IDX_W'(count_ext - EXT_W'(2));
	assign wr_idx    = IDX_W'(count_ext);

	assign stat.out_busy = out_valid_q && !out_ready;

	// hold the item and fetch the top entry and the minimum just below it
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= mode;
			val_q      <= push_value;
			rd_value_q <= value_mem[top_idx];
			rd_pmin_q  <= pmin_mem[below_idx];
		end
	end

	always_comb begin
		push_ok  = (op_q == msk_pkg::MODE_PUSH) && (count_q < cap_eff);
		pop_ok   = (op_q == msk_pkg::MODE_POP) && (count_q != '0);
		push_min = val_q;
		if (count_q != '0 && $signed(cur_min_q) < $signed(val_q)) begin
			push_min = cur_min_q;
		end
		count_d  = count_q;
		min_d    = cur_min_q;
		popped_d = '0;
		status_d = msk_pkg::ST_DONE;
		unique case (op_q)
			msk_pkg::MODE_PUSH: begin
				if (push_ok) begin
					count_d = count_q + msk_pkg::CNT_W'(1);
					min_d   = push_min;
				end else begin
					status_d = msk_pkg::ST_FULL;
				end
			end
			msk_pkg::MODE_POP: begin
				if (pop_ok) begin
					count_d  = count_q - msk_pkg::CNT_W'(1);
					popped_d = rd_value_q;
					min_d    = (count_q == msk_pkg::CNT_W'(1)) ? '0 : rd_pmin_q;
				end else begin
					status_d = msk_pkg::ST_EMPTY;
				end
			end
			default: status_d = msk_pkg::ST_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && push_ok) begin
			value_mem[wr_idx] <= val_q;
			pmin_mem[wr_idx]  <= push_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_min_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= count_d;
				cur_min_q   <= min_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_popped_q <= popped_d;
			out_min_q    <= min_d;
			out_count_q  <= count_d;
			out_status_q <= status_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = out_popped_q;
	assign current_min  = out_min_q;
	assign entry_count  = out_count_q;
	assign status       = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= msk_pkg::CNT_W'(DEPTH_LIM))
		else $error("stack count past storage depth");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed item not presented");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != msk_pkg::ST_DONE) |-> (out_popped_q == '0))
		else $error("rejected item carries a popped value");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (cur_min_q == '0))
		else $error("empty stack with nonzero minimum");

endmodule

### design/min_tracking_stack_top.sv
// Top level of the minimum-tracking stack: config port, controller and datapath.
// The result goes valid once its item has been captured and then committed, and
// no new item is taken until that commit, set by the capture/commit sequence;
// a result held by the receiver holds the commit step, and with it in_ready.
// Reset clears the count, the running minimum and the capacity (back to 16);
// the memories are not cleared, since only entries below the count are ever used.
module min_tracking_stack_top #(
	parameter int STACK_DEPTH = msk_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [msk_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [msk_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [msk_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	// input items
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic signed [msk_pkg::DATA_W-1:0]  push_value,
	// result items
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [msk_pkg::DATA_W-1:0]  popped_value,
	output logic signed [msk_pkg::DATA_W-1:0]  current_min,
	output logic [msk_pkg::CNT_W-1:0]          entry_count,
	output logic [1:0]                         status
);

	msk_pkg::ctrl_cmd_t        cmd;
	msk_pkg::dp_stat_t         stat;
	logic [msk_pkg::CNT_W-1:0] cap_eff;

	// capacity register; hands down the clamped limit the push check uses
	msk_cfg #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_eff (cap_eff)
	);

	// two-state sequencer: take an item, then commit it once the result slot frees
	msk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack storage, running minimum and the output register
	msk_dpath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cap_eff      (cap_eff),
		.mode         (mode),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.popped_value (popped_value),
		.current_min  (current_min),
		.entry_count  (entry_count),
		.status       (status)
	);

endmodule
